@@ rtl/skt_pkg.sv @@
// Shared constants, status codes and result type of the sorted key table.
package skt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned KEY_W       = 27;
  localparam int unsigned PAY_W       = 32;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned STATUS_W    = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [PAY_W-1:0]    payload;
    logic [POS_W-1:0]    position;
  } res_t;

endpackage

@@ rtl/skt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/skt_ctrl.sv @@
// Sequencer that runs the binary search, the shift-up on insert and the entry count.
module skt_ctrl #(
  parameter int unsigned DEPTH = skt_pkg::TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned RW    = skt_pkg::KEY_W + skt_pkg::PAY_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       busy_o,
  input  logic                       operation_i,
  input  logic [skt_pkg::KEY_W-1:0]  key_i,
  input  logic [skt_pkg::PAY_W-1:0]  payload_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output skt_pkg::res_t              res_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [RW-1:0]              ram_wdata_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  logic [RW-1:0]              ram_rdata_i
);

  import skt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    lo_q, lo_d;
  logic [CW-1:0]    hi_q, hi_d;
  logic [AW-1:0]    mid_q, mid_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    wptr_q, wptr_d;
  logic             wpend_q, wpend_d;
  logic             op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  res_t             res_q, res_d;
  logic [CW:0]      sum;
  logic [AW-1:0]    mid;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;

  assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum[AW:1];
  assign rd_key = ram_rdata_i[RW-1 -: KEY_W];
  assign rd_pay = ram_rdata_i[PAY_W-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    wpend_d     = wpend_q;
    op_d        = op_q;
    key_d       = key_q;
    pay_d       = pay_q;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wptr_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = mid;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          key_d   = key_i;
          pay_d   = payload_i;
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (lo_q < hi_q) begin
          mid_d   = mid;
          state_d = S_CMP;
        end else if (op_q == OP_LOOKUP) begin
          res_d   = '{status: ST_NOT_FOUND, payload: '0, position: '0};
          state_d = S_RESP;
        end else if (cnt_q == CW'(DEPTH)) begin
          res_d   = '{status: ST_FULL, payload: '0, position: '0};
          state_d = S_RESP;
        end else begin
          ptr_d   = cnt_q[AW-1:0];
          idx_d   = lo_q[AW-1:0];
          wpend_d = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_CMP: begin
        if (rd_key < key_q) begin
          lo_d    = CW'(mid_q) + CW'(1);
          state_d = S_PROBE;
        end else if (rd_key > key_q) begin
          hi_d    = CW'(mid_q);
          state_d = S_PROBE;
        end else begin
          if (op_q == OP_LOOKUP) begin
            res_d = '{status: ST_FOUND, payload: rd_pay, position: POS_W'(mid_q)};
          end else begin
            res_d = '{status: ST_DUPLICATE, payload: '0, position: POS_W'(mid_q)};
          end
          state_d = S_RESP;
        end
      end
      S_SHIFT: begin
        // The entry read in the previous cycle lands one slot higher.
        if (wpend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = wptr_q;
          ram_wdata_o = ram_rdata_i;
        end
        if (ptr_q != idx_q) begin
          ram_raddr_o = ptr_q - AW'(1);
          wpend_d     = 1'b1;
          wptr_d      = ptr_q;
          ptr_d       = ptr_q - AW'(1);
        end else if (!wpend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = idx_q;
          ram_wdata_o = {key_q, pay_q};
          cnt_d       = cnt_q + CW'(1);
          res_d       = '{status: ST_INSERTED, payload: '0, position: POS_W'(idx_q)};
          state_d     = S_RESP;
        end else begin
          wpend_d = 1'b0;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wpend_q <= wpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    idx_q  <= idx_d;
    ptr_q  <= ptr_d;
    wptr_q <= wptr_d;
    op_q   <= op_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

endmodule

@@ rtl/sorted_key_table_insert_search.sv @@
// Sorted key table: one insert or lookup beat at a time, binary search plus shift-up on insert.
// Lookup: the result follows the binary search, which stops early on a hit.
// Probes are at most clog2(entries + 1).
// Insert: the search, then each entry above the insertion point moves up one slot, then the new record is written.
// An insert at the front of a 63-entry table is the worst case.
// Input stall stays high from accept until the result moves into the output register.
// Reset empties the table at once; stored records are not cleared.
module sorted_key_table_insert_search #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [skt_pkg::KEY_W-1:0]     key_i,
  input  logic [skt_pkg::PAY_W-1:0]     payload_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [skt_pkg::STATUS_W-1:0]  status_o,
  output logic [skt_pkg::PAY_W-1:0]     found_payload_o,
  output logic [skt_pkg::POS_W-1:0]     position_o
);

  import skt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned RW = KEY_W + PAY_W;

  logic          busy;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  logic          out_valid_q, out_valid_d;
  res_t          out_q, out_d;

  skt_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .RW    (RW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .busy_o      (busy),
    .operation_i (operation_i),
    .key_i       (key_i),
    .payload_i   (payload_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  skt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o      = busy;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign found_payload_o = out_q.payload;
  assign position_o      = out_q.position;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block did not go busy after an accepted beat");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a beat in progress");

  a_payload_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FOUND) |-> found_payload_o == '0)
    else $error("nonzero payload on a result other than found");

  a_position_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_NOT_FOUND) || (status_o == ST_FULL)) |->
      position_o == '0)
    else $error("nonzero position on not found or table full");

endmodule
